// File: rtl/trbc_pkg.sv
// ----------------------------------------------------------------------------
// trbc_pkg: shared definitions for the table round block cipher
// Byte tables, byte order list, register indexes and key rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package trbc_pkg;

    localparam int BLOCK_W = 64;
    localparam int LIMIT_W = 8;
    localparam int KEY_W   = 80;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] CFG_KEY_LOW  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_KEY_HIGH = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 8'd254;
    localparam logic [3:0]         KEY_BYTES = 4'd10;

    typedef logic [7:0] t_byte;

    localparam t_byte ORDER [24] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
        8'd0, 8'd3, 8'd6, 8'd1, 8'd4, 8'd7, 8'd2, 8'd5
    };

    localparam t_byte TAB_A [256] = '{
        8'hDA, 8'h26, 8'hE8, 8'h72, 8'h11, 8'h52, 8'h3E, 8'h46,
        8'h32, 8'hFF, 8'h8C, 8'h1E, 8'hA7, 8'hBE, 8'h2C, 8'h29,
        8'h5F, 8'h86, 8'h7E, 8'h75, 8'h0A, 8'h08, 8'hA5, 8'h21,
        8'h61, 8'hFB, 8'h7A, 8'h58, 8'h60, 8'hF7, 8'h81, 8'h4F,
        8'hE4, 8'hFC, 8'hDF, 8'hB1, 8'hBB, 8'h6A, 8'h02, 8'hB3,
        8'h0B, 8'h6E, 8'h5D, 8'h5C, 8'hD5, 8'hCF, 8'hCA, 8'h2A,
        8'h14, 8'hB7, 8'h90, 8'hF3, 8'hD9, 8'h37, 8'h3A, 8'h59,
        8'h44, 8'h69, 8'hC9, 8'h78, 8'h30, 8'h16, 8'h39, 8'h9A,
        8'h0D, 8'h05, 8'h1F, 8'h8B, 8'h5E, 8'hEE, 8'h1B, 8'hC4,
        8'h76, 8'h43, 8'hBD, 8'hEB, 8'h42, 8'hEF, 8'hF9, 8'hD0,
        8'h4D, 8'hE3, 8'hF4, 8'h57, 8'h56, 8'hA3, 8'h0F, 8'hA6,
        8'h50, 8'hFD, 8'hDE, 8'hD2, 8'h80, 8'h4C, 8'hD3, 8'hCB,
        8'hF8, 8'h49, 8'h8F, 8'h22, 8'h71, 8'h84, 8'h33, 8'hE0,
        8'h47, 8'hC2, 8'h93, 8'hBC, 8'h7C, 8'h3B, 8'h9C, 8'h7D,
        8'hEC, 8'hC3, 8'hF1, 8'h89, 8'hCE, 8'h98, 8'hA2, 8'hE1,
        8'hC1, 8'hF2, 8'h27, 8'h12, 8'h01, 8'hEA, 8'hE5, 8'h9B,
        8'h25, 8'h87, 8'h96, 8'h7B, 8'h34, 8'h45, 8'hAD, 8'hD1,
        8'hB5, 8'hDB, 8'h83, 8'h55, 8'hB0, 8'h9E, 8'h19, 8'hD7,
        8'h17, 8'hC6, 8'h35, 8'hD8, 8'hF0, 8'hAE, 8'hD4, 8'h2B,
        8'h1D, 8'hA0, 8'h99, 8'h8A, 8'h15, 8'h00, 8'hAF, 8'h2D,
        8'h09, 8'hA8, 8'hF5, 8'h6C, 8'hA1, 8'h63, 8'h67, 8'h51,
        8'h3C, 8'hB2, 8'hC0, 8'hED, 8'h94, 8'h03, 8'h6F, 8'hBA,
        8'h3F, 8'h4E, 8'h62, 8'h92, 8'h85, 8'hDD, 8'hAB, 8'hFE,
        8'h10, 8'h2E, 8'h68, 8'h65, 8'hE7, 8'h04, 8'hF6, 8'h0C,
        8'h20, 8'h1C, 8'hA9, 8'h53, 8'h40, 8'h77, 8'h2F, 8'hA4,
        8'hFA, 8'h6D, 8'h73, 8'h28, 8'hE2, 8'hCD, 8'h79, 8'hC8,
        8'h97, 8'h66, 8'h8E, 8'h82, 8'h74, 8'h06, 8'hC7, 8'h88,
        8'h1A, 8'h4A, 8'h6B, 8'hCC, 8'h41, 8'hE9, 8'h9D, 8'hB8,
        8'h23, 8'h9F, 8'h3D, 8'hBF, 8'h8D, 8'h95, 8'hC5, 8'h13,
        8'hB9, 8'h24, 8'h5A, 8'hDC, 8'h64, 8'h18, 8'h38, 8'h91,
        8'h7F, 8'h5B, 8'h70, 8'h54, 8'h07, 8'hB6, 8'h4B, 8'h0E,
        8'h36, 8'hAC, 8'h31, 8'hE6, 8'hD6, 8'h48, 8'hAA, 8'hB4
    };

    localparam t_byte TAB_B [256] = '{
        8'h8E, 8'hD5, 8'h32, 8'h53, 8'h4B, 8'h18, 8'h7F, 8'h95,
        8'hBE, 8'h30, 8'hF3, 8'hE0, 8'h22, 8'hE1, 8'h68, 8'h90,
        8'h82, 8'hC8, 8'hA8, 8'h57, 8'h21, 8'hC5, 8'h38, 8'h73,
        8'h61, 8'h5D, 8'h5A, 8'hD6, 8'h60, 8'hB7, 8'h48, 8'h70,
        8'h2B, 8'h7A, 8'h1D, 8'hD1, 8'hB1, 8'hEC, 8'h7C, 8'hAA,
        8'h2F, 8'h1F, 8'h37, 8'h58, 8'h72, 8'h88, 8'hFF, 8'h87,
        8'h1C, 8'hCB, 8'h00, 8'hE6, 8'h4E, 8'hAB, 8'hEB, 8'hB3,
        8'hF7, 8'h59, 8'h71, 8'h6A, 8'h64, 8'h2A, 8'h55, 8'h4D,
        8'hFC, 8'hC0, 8'h51, 8'h01, 8'h2D, 8'hC4, 8'h54, 8'hE2,
        8'h9F, 8'h26, 8'h16, 8'h27, 8'hF2, 8'h9C, 8'h86, 8'h11,
        8'h05, 8'h29, 8'hA2, 8'h78, 8'h49, 8'hB2, 8'hA6, 8'hCA,
        8'h96, 8'hE5, 8'h33, 8'h3F, 8'h46, 8'hBA, 8'hD0, 8'hBB,
        8'h5F, 8'h84, 8'h98, 8'hE4, 8'hF9, 8'h0A, 8'h62, 8'hEE,
        8'hF6, 8'hCF, 8'h94, 8'hF0, 8'hEA, 8'h1E, 8'hBF, 8'h07,
        8'h9B, 8'hD9, 8'hE9, 8'h74, 8'hC6, 8'hA4, 8'hB9, 8'h56,
        8'h3E, 8'hDB, 8'hC7, 8'h15, 8'hE3, 8'h80, 8'hD7, 8'hED,
        8'hEF, 8'h13, 8'hAC, 8'hA1, 8'h91, 8'hC2, 8'h89, 8'h5B,
        8'h08, 8'h0B, 8'h4C, 8'h02, 8'h3A, 8'h5C, 8'hA9, 8'h3B,
        8'hCE, 8'h6B, 8'hA7, 8'hE7, 8'hCD, 8'h7B, 8'hA0, 8'h47,
        8'h09, 8'h6D, 8'hF8, 8'hF1, 8'h8B, 8'hB0, 8'h12, 8'h42,
        8'h4A, 8'h9A, 8'h17, 8'hB4, 8'h7E, 8'hAD, 8'hFE, 8'hFD,
        8'h2C, 8'hD3, 8'hF4, 8'hB6, 8'hA3, 8'hFA, 8'hDF, 8'hB8,
        8'hD4, 8'hDA, 8'h0F, 8'h50, 8'h93, 8'h66, 8'h6C, 8'h20,
        8'hD8, 8'h8A, 8'hDD, 8'h31, 8'h1A, 8'h8C, 8'h06, 8'hD2,
        8'h44, 8'hE8, 8'h23, 8'h43, 8'h6E, 8'h10, 8'h69, 8'h36,
        8'hBC, 8'h19, 8'h8D, 8'h24, 8'h81, 8'h14, 8'h40, 8'hC9,
        8'h6F, 8'h2E, 8'h45, 8'h52, 8'h41, 8'h92, 8'h34, 8'hFB,
        8'h5E, 8'h0D, 8'hF5, 8'h76, 8'h25, 8'h77, 8'h63, 8'h65,
        8'hAF, 8'h4F, 8'hCC, 8'h03, 8'h9D, 8'h0C, 8'h28, 8'h39,
        8'h85, 8'hDE, 8'hB5, 8'h7D, 8'h67, 8'h83, 8'hBD, 8'hC3,
        8'hDC, 8'h3C, 8'hAE, 8'h99, 8'h04, 8'h75, 8'h8F, 8'h97,
        8'hC1, 8'hA5, 8'h9E, 8'h35, 8'h0E, 8'h3D, 8'h1B, 8'h79
    };

    // bit 0 of byte k-1 moves into bit 7 of byte k, byte 9 wraps to byte 0
    function automatic logic [KEY_W-1:0] key_rotate(input logic [KEY_W-1:0] w);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int k = 0; k < 10; k++) begin
            r[8*k +: 7] = w[8*k+1 +: 7];
            r[8*k+7]    = w[(8*k+72) % 80];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/trbc_in_if.sv
// ----------------------------------------------------------------------------
// trbc_in_if: input word channel
// Valid/ready channel carrying one block, its round limit and order select.
// ----------------------------------------------------------------------------
`default_nettype none

interface trbc_in_if;
    logic                            valid;
    logic                            ready;
    logic [trbc_pkg::BLOCK_W-1:0]    block_in;
    logic [trbc_pkg::LIMIT_W-1:0]    round_limit;
    logic                            order_select;

    modport source (output valid, block_in, round_limit, order_select, input ready);
    modport sink   (input valid, block_in, round_limit, order_select, output ready);
endinterface

`default_nettype wire

// File: rtl/trbc_out_if.sv
// ----------------------------------------------------------------------------
// trbc_out_if: output word channel
// Valid/ready channel carrying one transformed block.
// ----------------------------------------------------------------------------
`default_nettype none

interface trbc_out_if;
    logic                            valid;
    logic                            ready;
    logic [trbc_pkg::BLOCK_W-1:0]    block_out;

    modport source (output valid, block_out, input ready);
    modport sink   (input valid, block_out, output ready);
endinterface

`default_nettype wire

// File: rtl/trbc_round.sv
// ----------------------------------------------------------------------------
// trbc_round: one table round
// Picks source and destination bytes, keys and looks up the source byte,
// and folds the table output into the destination byte.
// ----------------------------------------------------------------------------
`default_nettype none

module trbc_round (
    input  wire logic [trbc_pkg::BLOCK_W-1:0] i_blk,
    input  wire logic [7:0]                   i_kb,
    input  wire logic [3:0]                   i_pos,
    input  wire logic                         i_perm,
    output      logic [trbc_pkg::BLOCK_W-1:0] o_blk
);

    logic [3:0] dst_pos;
    logic [4:0] src_ix;
    logic [4:0] dst_ix;
    logic [2:0] src_b;
    logic [2:0] dst_b;
    logic [7:0] src;
    logic [7:0] lut_ix;
    logic [7:0] t;

    always_comb begin
        dst_pos = i_pos + 4'd1;
        src_ix  = {1'b0, i_pos}   + (i_perm ? 5'd8 : 5'd0);
        dst_ix  = {1'b0, dst_pos} + (i_perm ? 5'd8 : 5'd0);
        src_b   = trbc_pkg::ORDER[src_ix][2:0];
        dst_b   = trbc_pkg::ORDER[dst_ix][2:0];
        src     = i_blk[8*src_b +: 8];
        lut_ix  = src ^ i_kb;
        t       = i_kb[0] ? trbc_pkg::TAB_A[lut_ix] : trbc_pkg::TAB_B[lut_ix];
        o_blk   = i_blk;
        o_blk[8*dst_b +: 8] = i_blk[8*dst_b +: 8] ^ t;
    end

endmodule

`default_nettype wire

// File: rtl/table_round_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// table_round_block_cipher_unit: table round block cipher, top level
// Sequencer around a single shared round unit with key copy and rotation.
// ----------------------------------------------------------------------------
// A word runs one round per cycle from round 0 through its round limit (a
// round limit of 255 runs as 254) through the single shared table round
// unit; the wait state then hands the result to the output register once
// the output is free, and the unit returns to idle to take the next word.
// Input ready is low while a word is in work; a result still waiting on
// the output holds the finished word in the wait state and blocks the next
// acceptance. The key registers must only be written while the block is idle.
`default_nettype none

module table_round_block_cipher_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [trbc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [trbc_pkg::CFG_W-1:0]    i_cfg_data,
    trbc_in_if.sink                            i_in,
    trbc_out_if.source                         o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                      r_state;
    logic [63:0]                     r_key_low;
    logic [15:0]                     r_key_high;
    logic [trbc_pkg::KEY_W-1:0]      r_work;
    logic [trbc_pkg::BLOCK_W-1:0]    r_blk;
    logic [trbc_pkg::LIMIT_W-1:0]    r_last;
    logic [trbc_pkg::LIMIT_W-1:0]    r_rnd;
    logic [3:0]                      r_kix;
    logic                            r_perm;
    logic                            r_out_valid;
    logic [trbc_pkg::BLOCK_W-1:0]    r_out_blk;

    logic [trbc_pkg::KEY_W-1:0]      n_work;
    logic [7:0]                      kb;
    logic [trbc_pkg::BLOCK_W-1:0]    blk_next;
    logic                            in_fire;
    logic                            out_free;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.block_out = r_out_blk;

    always_comb begin
        n_work = (r_kix == 4'd0) ? trbc_pkg::key_rotate(r_work) : r_work;
        kb     = n_work[8*r_kix +: 8];
    end

    trbc_round u_round (
        .i_blk  (r_blk),
        .i_kb   (kb),
        .i_pos  (r_rnd[3:0]),
        .i_perm (r_perm),
        .o_blk  (blk_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    trbc_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    trbc_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_state == ST_WAIT && out_free)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (in_fire)
                        r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_rnd == r_last)
                        r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (out_free)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_blk  <= i_in.block_in;
                    r_work <= {r_key_high, r_key_low};
                    r_last <= (i_in.round_limit > trbc_pkg::LIMIT_MAX) ?
                              trbc_pkg::LIMIT_MAX : i_in.round_limit;
                    r_perm <= i_in.order_select;
                    r_rnd  <= '0;
                    r_kix  <= '0;
                end
            end
            ST_RUN: begin
                r_blk  <= blk_next;
                r_work <= n_work;
                r_rnd  <= r_rnd + 8'd1;
                r_kix  <= (r_kix == trbc_pkg::KEY_BYTES - 4'd1) ? 4'd0 : r_kix + 4'd1;
            end
            ST_WAIT: begin
                if (out_free)
                    r_out_blk <= r_blk;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: table round block cipher unit
// Streams blocks with a chosen round limit and byte order through the unit
// under several keys, predicts each output block on acceptance and checks
// the outputs in order. Covers round limit and key extremes, back-pressure,
// random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------

module testbench;

    localparam int SETTLE_CYCLES = 300;
    localparam int RX_HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [63:0] blk;
        logic [7:0]  lim;
        logic        ord;
    } cipher_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [trbc_pkg::IDX_W-1:0] i_cfg_idx;
    logic [trbc_pkg::CFG_W-1:0] i_cfg_data;

    trbc_in_if  in_ch ();
    trbc_out_if out_ch ();

    table_round_block_cipher_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    cipher_word_t pending_words [$];
    logic [63:0]  expected_blocks [$];
    logic [63:0]  key_low_m = '0;
    logic [15:0]  key_high_m = '0;
    logic         in_taken = 1'b0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    int           rx_hold = 0;
    int           fault_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [63:0] cipher_block(input logic [63:0] blk, input logic [7:0] lim,
                                                 input logic ord, input logic [63:0] klo,
                                                 input logic [15:0] khi);
        logic [7:0]  data [8];
        logic [79:0] work;
        logic [79:0] turned;
        logic [7:0]  kb;
        logic [7:0]  t;
        logic [63:0] res;
        int          last;
        int          base;
        int          dst;
        for (int k = 0; k < 8; k++) data[k] = blk[8*k +: 8];
        work = {khi, klo};
        last = (lim > 8'd254) ? 254 : int'(lim);
        base = ord ? 8 : 0;
        for (int i = 0; i <= last; i++) begin
            // every tenth round: each key byte shifts right, bit 0 of the byte below enters
            if (i % 10 == 0) begin
                for (int k = 0; k < 10; k++)
                    turned[8*k +: 8] = {work[8*((k+9)%10)], work[8*k+1 +: 7]};
                work = turned;
            end
            kb = work[8*(i%10) +: 8];
            t = data[trbc_pkg::ORDER[(i%16) + base]] ^ kb;
            t = kb[0] ? trbc_pkg::TAB_A[t] : trbc_pkg::TAB_B[t];
            dst = trbc_pkg::ORDER[((i+1)%16) + base];
            data[dst] = data[dst] ^ t;
        end
        for (int k = 0; k < 8; k++) res[8*k +: 8] = data[k];
        return res;
    endfunction

    function automatic logic [7:0] pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'($urandom_range(40));
        if (r < 90) return 8'($urandom_range(255));
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd254;
            2: return 8'd255;
            3: return 8'd9;
            4: return 8'd10;
            default: return 8'd16;
        endcase
    endfunction

    function automatic cipher_word_t random_word();
        cipher_word_t w;
        int r;
        r = $urandom_range(99);
        if (r < 5) w.blk = '0;
        else if (r < 10) w.blk = '1;
        else w.blk = {$urandom, $urandom};
        w.lim = pick_limit();
        w.ord = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    task automatic send_block(input logic [63:0] blk, input logic [7:0] lim, input logic ord);
        cipher_word_t w;
        w.blk = blk;
        w.lim = lim;
        w.ord = ord;
        pending_words.push_back(w);
    endtask

    // called at a falling edge with the unit idle
    task automatic load_key(input logic [63:0] lo, input logic [15:0] hi);
        logic [63:0] hi_word;
        hi_word = {$urandom, $urandom};
        hi_word[15:0] = hi;
        i_cfg_we = 1'b1;
        i_cfg_idx = trbc_pkg::CFG_KEY_LOW;
        i_cfg_data = lo;
        @(negedge i_clk);
        i_cfg_idx = trbc_pkg::CFG_KEY_HIGH;
        i_cfg_data = hi_word;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        key_low_m = lo;
        key_high_m = hi;
    endtask

    task automatic wait_quiet();
        while (pending_words.size() != 0 || in_ch.valid || expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // input driver: one assignment per signal per falling edge
    always @(negedge i_clk) begin
        if (in_taken || !in_ch.valid) begin
            in_taken = 1'b0;
            if (pending_words.size() != 0 && !(tx_idle_on && $urandom_range(99) < 10)) begin
                in_ch.valid = 1'b1;
                in_ch.block_in = pending_words[0].blk;
                in_ch.round_limit = pending_words[0].lim;
                in_ch.order_select = pending_words[0].ord;
                pending_words.delete(0);
            end else begin
                in_ch.valid = 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            out_ch.ready = 1'b0;
            rx_hold--;
        end else if (rx_idle_on) begin
            out_ch.ready = ($urandom_range(99) >= 10);
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expected_blocks.push_back(cipher_block(in_ch.block_in, in_ch.round_limit,
                                                   in_ch.order_select, key_low_m, key_high_m));
            in_taken = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_blocks.size() == 0) begin
                note_fault($sformatf("unexpected word: block_out %h", out_ch.block_out));
            end else begin
                if (out_ch.block_out !== expected_blocks[0])
                    note_fault($sformatf("block_out mismatch: expected %h got %h",
                                         expected_blocks[0], out_ch.block_out));
                expected_blocks.delete(0);
            end
        end
    end

    // key registers still at their reset value
    task automatic test_reset_key();
        send_block('0, 8'd0, 1'b0);
        send_block('1, 8'd254, 1'b1);
        send_block('1, 8'd255, 1'b0);
        wait_quiet();
    endtask

    // rotation points, byte order wrap and round limit saturation
    task automatic test_edge_limits();
        logic [7:0] limits [11];
        limits = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd11, 8'd15, 8'd16, 8'd20, 8'd253, 8'd254, 8'd255};
        load_key(64'h0123_4567_89AB_CDEF, 16'h0155);
        for (int n = 0; n < 11; n++)
            send_block((n % 3 == 0) ? 64'h5555_5555_5555_5555 :
                       (n % 3 == 1) ? 64'hAAAA_AAAA_AAAA_AAAA : {$urandom, $urandom},
                       limits[n], 1'(n % 2));
        wait_quiet();
    endtask

    // all ones key, and keys that pin the table select for every round before the second rotation
    task automatic test_key_extremes();
        load_key('1, '1);
        send_block({$urandom, $urandom}, 8'd254, 1'b0);
        send_block({$urandom, $urandom}, 8'd254, 1'b1);
        wait_quiet();
        load_key(64'hFEFE_FEFE_FEFE_FEFE, 16'hFEFE);
        send_block({$urandom, $urandom}, 8'd9, 1'b0);
        send_block({$urandom, $urandom}, 8'd9, 1'b1);
        wait_quiet();
        load_key(64'h0101_0101_0101_0101, 16'h0101);
        send_block({$urandom, $urandom}, 8'd9, 1'b0);
        send_block({$urandom, $urandom}, 8'd9, 1'b1);
        wait_quiet();
    endtask

    task automatic test_burst();
        cipher_word_t w;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        load_key({$urandom, $urandom}, 16'($urandom_range(65535)));
        for (int n = 0; n < 40; n++) begin
            w = random_word();
            send_block(w.blk, 8'($urandom_range(12)), w.ord);
        end
        wait_quiet();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // output held off while the sender keeps offering words
    task automatic test_rx_stall();
        cipher_word_t w;
        tx_idle_on = 1'b0;
        rx_hold = RX_HOLD_CYCLES;
        for (int n = 0; n < 8; n++) begin
            w = random_word();
            send_block(w.blk, 8'($urandom_range(12)), w.ord);
        end
        wait_quiet();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        cipher_word_t w;
        for (int p = 0; p < 2; p++) begin
            for (int n = 0; n < 4; n++) begin
                w = random_word();
                send_block(w.blk, w.lim, w.ord);
            end
            wait_quiet();
        end
    endtask

    task automatic test_random_stream();
        cipher_word_t w;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_key('0, '0);
                1: load_key('1, '1);
                default: load_key({$urandom, $urandom}, 16'($urandom_range(65535)));
            endcase
            for (int n = 0; n < 90; n++) begin
                w = random_word();
                send_block(w.blk, w.lim, w.ord);
            end
            wait_quiet();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = trbc_pkg::CFG_KEY_LOW;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.block_in = '0;
        in_ch.round_limit = '0;
        in_ch.order_select = 1'b0;
        out_ch.ready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_edge_limits();
        test_key_extremes();
        test_burst();
        test_rx_stall();
        test_sender_pause();
        test_random_stream();

        if (expected_blocks.size() != 0)
            note_fault($sformatf("%0d words never came out", expected_blocks.size()));
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
